@@ design/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int OP_W    = 2;
   localparam int PRIO_W  = 8;
   localparam int MSG_W   = 16;
   localparam int STAT_W  = 2;
   localparam int ECNT_W  = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // One stored entry
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [MSG_W-1:0]  msg;
   } entry_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic      do_insert;
      logic      do_remove;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ design/spq_cell.sv @@
`default_nettype none

module spq_cell (
   input  wire logic                  clock,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire logic                  occupied,
   input  wire logic                  left_keep,
   input  wire spq_pkg::entry_type    left_entry,
   input  wire spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type         entry,
   output spq_pkg::entry_type         entry_next,
   output logic                       keep
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // Stored entry stays in place when it outranks or ties the new one
   assign keep = occupied && (entry_ff.prio >= ctrl.new_entry.prio);

   // Hold, take the new entry, or shift from a neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = ctrl.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.do_remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

@@ design/stable_priority_queue.sv @@
`default_nettype none

// Bounded priority queue, highest priority at the head, ties leave first in first out.
// Input channel req_*: one transaction carries an operation (insert, remove head,
// clear) with the priority and message handle used by insert. Output channel rsp_*:
// exactly one transaction per request, giving the status, the head entry and the
// entry count after the operation.
// Storage is a row of compare-and-shift cells, one per slot; every cell decides
// in the same cycle whether to hold, take the new entry or take a neighbor's.
// The response is registered and is valid in the cycle after the request is accepted.
// The block takes one request per cycle while the receiver keeps rsp_tready high.
// A registered response stage sits between the channels: req_tready stays high
// while the response register is empty or being taken, so a stalled receiver
// holds the response and blocks new requests until rsp_tready returns.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; slot contents are not cleared, only the count.
// Insert on a full queue is rejected with status full; remove on an empty queue
// reports status empty; an undefined operation code leaves the queue unchanged.
module stable_priority_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] operation, [9:2] priority_req, [25:10] message_handle, [31:26] zero
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [2] head_valid, [10:3] head_priority, [26:11] head_message,
   // [31:27] entry_count
   output logic [31:0]      rsp_tdata
);

   localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
   localparam int CW    = spq_pkg::COUNT_W;

   logic [spq_pkg::OP_W-1:0]   req_op;
   logic                       req_accept;
   logic                       is_full;
   logic                       is_empty;
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [spq_pkg::STAT_W-1:0] status;
   spq_pkg::cell_ctrl_type     ctrl;
   spq_pkg::entry_type         cell_entry [DEPTH];
   spq_pkg::entry_type         cell_next  [DEPTH];
   logic                       cell_keep  [DEPTH];
   logic [CW+spq_pkg::ECNT_W-1:0] count_ext;
   logic                       head_valid;
   spq_pkg::entry_type         head;
   logic                       rsp_valid_ff;
   logic [31:0]                rsp_data_ff;

   // Request decode
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = req_tdata[1:0];
   assign is_full    = (count_ff == CW'(DEPTH));
   assign is_empty   = (count_ff == '0);

   always_comb begin
      ctrl.do_insert = 1'b0;
      ctrl.do_remove = 1'b0;
      ctrl.new_entry.prio = req_tdata[9:2];
      ctrl.new_entry.msg  = req_tdata[25:10];
      count_in = count_ff;
      status   = spq_pkg::STAT_DONE;
      if (req_accept) begin
         unique case (req_op)
            spq_pkg::OP_INSERT: begin
               if (is_full) begin
                  status = spq_pkg::STAT_FULL;
               end else begin
                  ctrl.do_insert = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            spq_pkg::OP_REMOVE: begin
               if (is_empty) begin
                  status = spq_pkg::STAT_EMPTY;
               end else begin
                  ctrl.do_remove = 1'b1;
                  count_in = count_ff - CW'(1);
               end
            end
            spq_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Row of cells, slot 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               left_keep;
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_keep  = 1'b1;
         assign left_entry = ctrl.new_entry;
      end else begin : g_inner
         assign left_keep  = cell_keep[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > CW'(i)),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .entry_next  (cell_next[i]),
         .keep        (cell_keep[i])
      );
   end

   // Response fields describe the queue after the operation
   assign head_valid = (count_in != '0);
   assign head       = head_valid ? cell_next[0] : '0;
   assign count_ext  = {{spq_pkg::ECNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {count_ext[spq_pkg::ECNT_W-1:0], head.msg, head.prio,
                         head_valid, status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above queue depth");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_op == spq_pkg::OP_INSERT && is_full
      |=> rsp_tdata[1:0] == spq_pkg::STAT_FULL && $stable(count_ff))
      else $error("insert on full queue not rejected");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_op == spq_pkg::OP_REMOVE && is_empty
      |=> rsp_tdata[1:0] == spq_pkg::STAT_EMPTY && count_ff == '0)
      else $error("remove on empty queue not flagged");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      $past(req_accept) |-> rsp_tdata[2] == (count_ff != '0))
      else $error("head valid disagrees with count");

endmodule

`default_nettype wire

@@ tb/tb_stable_priority_queue.sv @@
`timescale 1ns / 100ps

module tb_stable_priority_queue;

   // Code with no meaning: the block must ignore it
   localparam logic [spq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1500;

   // Fields of one response transaction
   typedef struct packed {
      logic [spq_pkg::STAT_W-1:0] status;
      logic                       head_valid;
      logic [spq_pkg::PRIO_W-1:0] head_prio;
      logic [spq_pkg::MSG_W-1:0]  head_msg;
      logic [spq_pkg::ECNT_W-1:0] count;
   } queue_report_type;

   // One directed request, with a hand-written response where it is obvious
   typedef struct packed {
      logic [spq_pkg::OP_W-1:0]   op;
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic [spq_pkg::MSG_W-1:0]  msg;
      logic                       known;
      queue_report_type           want;
   } plan_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   // Side band that travels with the request being offered
   logic             row_known = 1'b0;
   queue_report_type row_want  = '0;

   // Shadow queue, kept sorted like the block's cell row
   spq_pkg::entry_type shadow_slot [spq_pkg::QUEUE_DEPTH];
   int                 shadow_count = 0;

   queue_report_type pending_reports [$];
   plan_row_type     plan [$];

   int mismatches = 0;
   int n_insert = 0, n_rejected = 0, n_remove = 0, n_remove_empty = 0;
   int n_clear = 0, n_unused = 0, n_responses = 0;
   int cycle_no = 0;
   int ready_hold = 0;

   stable_priority_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one operation to the shadow queue and returns the response it implies
   function automatic queue_report_type queue_apply(input logic [spq_pkg::OP_W-1:0] op,
                                                    input logic [spq_pkg::PRIO_W-1:0] prio,
                                                    input logic [spq_pkg::MSG_W-1:0] msg);
      queue_report_type rep;
      int pos;
      rep = '0;
      rep.status = spq_pkg::STAT_DONE;
      case (op)
         spq_pkg::OP_INSERT: begin
            n_insert++;
            if (shadow_count >= spq_pkg::QUEUE_DEPTH) begin
               rep.status = spq_pkg::STAT_FULL;
               n_rejected++;
            end else begin
               // new entry goes behind everything of equal or higher priority
               pos = 0;
               while (pos < shadow_count && shadow_slot[pos].prio >= prio)
                  pos++;
               for (int k = shadow_count; k > pos; k--)
                  shadow_slot[k] = shadow_slot[k-1];
               shadow_slot[pos].prio = prio;
               shadow_slot[pos].msg  = msg;
               shadow_count++;
            end
         end
         spq_pkg::OP_REMOVE: begin
            n_remove++;
            if (shadow_count == 0) begin
               rep.status = spq_pkg::STAT_EMPTY;
               n_remove_empty++;
            end else begin
               for (int k = 1; k < shadow_count; k++)
                  shadow_slot[k-1] = shadow_slot[k];
               shadow_count--;
            end
         end
         spq_pkg::OP_CLEAR: begin
            n_clear++;
            shadow_count = 0;
         end
         default: begin
            n_unused++;
         end
      endcase
      if (shadow_count > 0) begin
         rep.head_valid = 1'b1;
         rep.head_prio  = shadow_slot[0].prio;
         rep.head_msg   = shadow_slot[0].msg;
      end
      rep.count = shadow_count[spq_pkg::ECNT_W-1:0];
      return rep;
   endfunction

   // Mostly back to back, sometimes short waits, rarely long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(3, 1);
      else if (r < 98)
         return $urandom_range(10, 4);
      else
         return $urandom_range(40, 20);
   endfunction

   function automatic plan_row_type row_predicted(input logic [spq_pkg::OP_W-1:0] op,
                                                  input logic [spq_pkg::PRIO_W-1:0] prio,
                                                  input logic [spq_pkg::MSG_W-1:0] msg);
      plan_row_type row;
      row = '0;
      row.op   = op;
      row.prio = prio;
      row.msg  = msg;
      return row;
   endfunction

   function automatic plan_row_type row_known_result(input logic [spq_pkg::OP_W-1:0] op,
                                                     input logic [spq_pkg::PRIO_W-1:0] prio,
                                                     input logic [spq_pkg::MSG_W-1:0] msg,
                                                     input queue_report_type want);
      plan_row_type row;
      row = row_predicted(op, prio, msg);
      row.known = 1'b1;
      row.want  = want;
      return row;
   endfunction

   task automatic field_error(input string name, input int want, input int got);
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
   endtask

   // Offer one request (called at a falling edge) and hold it until accepted
   task automatic offer_request(input plan_row_type row, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, row.msg, row.prio, row.op};
      row_known  <= row.known;
      row_want   <= row.want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop sending until every outstanding response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver back-pressure, with quiet windows in which no new stall begins
   always @(negedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (cycle_no % 600 >= 150)
            ready_hold <= pick_gap();
      end
   end

   // Check responses against the oldest expectation, then record new requests
   always @(posedge clock) begin : watch_channels
      queue_report_type got;
      queue_report_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_responses++;
            got.status     = rsp_tdata[1:0];
            got.head_valid = rsp_tdata[2];
            got.head_prio  = rsp_tdata[10:3];
            got.head_msg   = rsp_tdata[26:11];
            got.count      = rsp_tdata[31:27];
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response transaction, actual 0x%08h",
                        $time, rsp_tdata);
            end else begin
               want = pending_reports.pop_front();
               if (got.status !== want.status)
                  field_error("status", want.status, got.status);
               if (got.head_valid !== want.head_valid)
                  field_error("head_valid", want.head_valid, got.head_valid);
               if (got.head_prio !== want.head_prio)
                  field_error("head_priority", want.head_prio, got.head_prio);
               if (got.head_msg !== want.head_msg)
                  field_error("head_message", want.head_msg, got.head_msg);
               if (got.count !== want.count)
                  field_error("entry_count", want.count, got.count);
            end
         end
         if (req_tvalid && req_tready) begin
            // the shadow queue always advances, even where the answer is typed in
            want = queue_apply(req_tdata[1:0], req_tdata[9:2], req_tdata[25:10]);
            if (row_known)
               want = row_want;
            pending_reports.push_back(want);
         end
      end
   end

   // Stimulus
   initial begin
      logic [spq_pkg::OP_W-1:0]   op;
      logic [spq_pkg::PRIO_W-1:0] prio;
      int                         insert_pct;
      int                         r;

      // Directed: empty-queue cases, extremes, ties, fill to full, reject, clear
      plan.push_back(row_known_result(spq_pkg::OP_REMOVE, 8'h00, 16'h0000,
                                      '{spq_pkg::STAT_EMPTY, 1'b0, 8'h00, 16'h0000, 5'd0}));
      plan.push_back(row_known_result(spq_pkg::OP_CLEAR,  8'hFF, 16'hFFFF,
                                      '{spq_pkg::STAT_DONE, 1'b0, 8'h00, 16'h0000, 5'd0}));
      plan.push_back(row_known_result(OP_UNUSED, 8'hFF, 16'hFFFF,
                                      '{spq_pkg::STAT_DONE, 1'b0, 8'h00, 16'h0000, 5'd0}));
      plan.push_back(row_known_result(spq_pkg::OP_INSERT, 8'h00, 16'h0000,
                                      '{spq_pkg::STAT_DONE, 1'b1, 8'h00, 16'h0000, 5'd1}));
      plan.push_back(row_known_result(spq_pkg::OP_INSERT, 8'hFF, 16'hFFFF,
                                      '{spq_pkg::STAT_DONE, 1'b1, 8'hFF, 16'hFFFF, 5'd2}));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'hFF, 16'h1234));
      plan.push_back(row_predicted(OP_UNUSED, 8'h5A, 16'hA5A5));
      plan.push_back(row_predicted(spq_pkg::OP_REMOVE, 8'h00, 16'h0000));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h80, 16'h0001));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h01, 16'h0002));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'hFE, 16'h8000));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h80, 16'h0003));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h7F, 16'h5555));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h55, 16'hAAAA));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'hAA, 16'h00FF));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h80, 16'h0004));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h00, 16'hFF00));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'hFF, 16'h0F0F));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h3C, 16'hF0F0));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'hC3, 16'h3333));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h01, 16'hCCCC));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h80, 16'h0005));
      plan.push_back(row_known_result(spq_pkg::OP_INSERT, 8'hFF, 16'hBEEF,
                                      '{spq_pkg::STAT_FULL, 1'b1, 8'hFF, 16'h1234, 5'd16}));
      plan.push_back(row_known_result(spq_pkg::OP_CLEAR,  8'h00, 16'h0000,
                                      '{spq_pkg::STAT_DONE, 1'b0, 8'h00, 16'h0000, 5'd0}));
      plan.push_back(row_predicted(spq_pkg::OP_INSERT, 8'h00, 16'hFFFF));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         offer_request(plan[i], pick_gap());
      drain_responses();

      // Random: phases that lean toward filling or draining, with ties common
      insert_pct = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            r = $urandom_range(2);
            insert_pct = (r == 0) ? 70 : (r == 1) ? 30 : 50;
         end
         if (i == RANDOM_ITEMS / 2)
            drain_responses();
         r = $urandom_range(99);
         if (r < 3)
            op = spq_pkg::OP_CLEAR;
         else if (r < 5)
            op = OP_UNUSED;
         else if (r < 5 + insert_pct)
            op = spq_pkg::OP_INSERT;
         else
            op = spq_pkg::OP_REMOVE;
         r = $urandom_range(99);
         if (r < 40)
            prio = 8'($urandom_range(3) * 85);
         else if (r < 55)
            prio = $urandom_range(1) ? 8'hFF : 8'h00;
         else
            prio = 8'($urandom_range(255));
         offer_request(row_predicted(op, prio, 16'($urandom_range(65535))),
                       (i % 200 < 50) ? 0 : pick_gap());
      end

      drain_responses();
      repeat (16) @(posedge clock);

      $display("Covered %0d responses: %0d inserts (%0d rejected full), %0d removes",
               n_responses, n_insert, n_rejected, n_remove);
      $display("  (%0d on empty), %0d clears, %0d unused op codes, %0d mismatches",
               n_remove_empty, n_clear, n_unused, mismatches);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d responses outstanding", $time, pending_reports.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
